FILE: rtl/fprs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fprs_pkg
// shared types and constants of the flash page record store
// ----------------------------------------------------------------------------
package fprs_pkg;

  // geometry
  localparam int unsigned SLOTS_PER_PAGE = 256;
  localparam int unsigned PAGE_COUNT     = 2;
  localparam int unsigned TOTAL_WORDS    = SLOTS_PER_PAGE * PAGE_COUNT;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned SLOT_W = $clog2(SLOTS_PER_PAGE);
  localparam int unsigned ADDR_W = $clog2(TOTAL_WORDS);
  localparam int unsigned IDX_W  = 8;

  localparam logic [WORD_W-1:0] ERASED_WORD = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] ZERO_WORD   = '0;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_e;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;

endpackage

FILE: rtl/fprs_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fprs_req_if
// request channel: operation, page and write word with valid/ready
// ----------------------------------------------------------------------------
interface fprs_req_if;
  logic               valid;
  logic               ready;
  fprs_pkg::cmd_e     cmd;
  logic               page_select;
  fprs_pkg::word_t    write_data;

  modport source (output valid, cmd, page_select, write_data, input ready);
  modport sink   (input valid, cmd, page_select, write_data, output ready);
endinterface

FILE: rtl/fprs_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fprs_rsp_if
// response channel: chosen slot and its word with valid/ready
// ----------------------------------------------------------------------------
interface fprs_rsp_if;
  logic               valid;
  logic               ready;
  fprs_pkg::idx_t     slot_index;
  fprs_pkg::word_t    read_data;

  modport source (output valid, slot_index, read_data, input ready);
  modport sink   (input valid, slot_index, read_data, output ready);
endinterface

FILE: rtl/fprs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fprs_ram
// generic single-port ram, one access per cycle, registered read
// ----------------------------------------------------------------------------
module fprs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/flash_page_record_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_page_record_store
// wear-levelled record store in one word memory, scanned one slot per cycle
// ----------------------------------------------------------------------------
// All slots live in a single-port memory of SLOTS_PER_PAGE * PAGE_COUNT
// 32-bit words. After reset the block sweeps the whole memory writing the
// erased word, one entry per cycle, and takes no request until that sweep
// is done. Each request then scans every slot of its page through the
// single memory port, one slot per cycle: a write stores its word in the
// first erased slot, or, on a full page, in the first slot holding the
// smallest value; a read picks the first slot holding the largest word
// that is neither zero nor erased, or slot 0 when there is none. After
// the scan the block passes through its drain and finish states; finish
// registers the response and returns to idle at the same clock edge, so
// back-to-back requests are spaced by the whole slot-by-slot scan through
// the single memory port. The response sits in an output register, so
// the next request is taken while an earlier response still waits to be
// taken; if that response is still waiting when the next scan ends, the
// block holds in its last state until the response is taken.
// ----------------------------------------------------------------------------
module flash_page_record_store (
  input  logic clk_i,
  input  logic rst_ni,
  fprs_req_if.sink   req_i,
  fprs_rsp_if.source rsp_o
);
  import fprs_pkg::*;

  // one-hot control states
  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,  // post-reset erase sweep
    ST_IDLE   = 5'b00010,  // waiting for a request
    ST_SCAN   = 5'b00100,  // issuing slot reads
    ST_DRAIN  = 5'b01000,  // last read data in flight
    ST_FINISH = 5'b10000   // write back and hand over the response
  } state_e;

  state_e state_q, state_d;

  // sweep and scan counters
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [SLOT_W-1:0] cnt_q, cnt_d;

  // request held for the whole operation
  cmd_e              cmd_q, cmd_d;
  word_t             wdata_q, wdata_d;
  logic [ADDR_W-1:0] base_q, base_d;

  // read pipeline tag, lines up with the registered ram output
  logic              rd_vld_q, rd_vld_d;
  logic [SLOT_W-1:0] rd_idx_q, rd_idx_d;

  // running selection
  logic [SLOT_W-1:0] best_idx_q, best_idx_d;
  word_t             best_val_q, best_val_d;
  logic              found_q, found_d;      // erased slot seen (write) or hit (read)
  word_t             word0_q, word0_d;      // contents of slot 0 for an empty read

  // response register
  logic              out_vld_q, out_vld_d;
  idx_t              out_idx_q, out_idx_d;
  word_t             out_data_q, out_data_d;

  // ram port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  word_t             ram_wdata;
  word_t             ram_rdata;

  logic              req_fire;
  logic              out_free;
  logic              finish_go;
  logic              page_sat;
  logic [SLOT_W+IDX_W-1:0] best_idx_wide;

  assign req_fire  = req_i.valid && req_i.ready;
  assign out_free  = !out_vld_q || rsp_o.ready;
  assign finish_go = (state_q == ST_FINISH) && out_free;

  // page number beyond the count saturates to the last page
  assign page_sat = (PAGE_COUNT < 2) ? 1'b0 : req_i.page_select;

  assign best_idx_wide = {{IDX_W{1'b0}}, best_idx_q};

  assign req_i.ready = (state_q == ST_IDLE);

  fprs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TOTAL_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // memory port arbitration by state
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = base_q + ADDR_W'(cnt_q);
    ram_wdata = ERASED_WORD;
    case (state_q)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_cnt_q;
      end
      ST_FINISH: begin
        ram_addr  = base_q + ADDR_W'(best_idx_q);
        ram_wdata = wdata_q;
        ram_we    = finish_go && (cmd_q == CMD_WRITE);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // control and selection
  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    cnt_d      = cnt_q;
    cmd_d      = cmd_q;
    wdata_d    = wdata_q;
    base_d     = base_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = cnt_q;
    best_idx_d = best_idx_q;
    best_val_d = best_val_q;
    found_d    = found_q;
    word0_d    = word0_q;
    out_vld_d  = out_vld_q && !rsp_o.ready;
    out_idx_d  = out_idx_q;
    out_data_d = out_data_q;

    // fold in the slot read issued last cycle
    if (rd_vld_q) begin
      if (rd_idx_q == '0) begin
        word0_d = ram_rdata;
      end
      if (cmd_q == CMD_WRITE) begin
        if (!found_q) begin
          if (ram_rdata == ERASED_WORD) begin
            found_d    = 1'b1;
            best_idx_d = rd_idx_q;
          end else if (ram_rdata < best_val_q) begin
            best_val_d = ram_rdata;
            best_idx_d = rd_idx_q;
          end
        end
      end else begin
        if (ram_rdata != ERASED_WORD && ram_rdata > best_val_q) begin
          found_d    = 1'b1;
          best_val_d = ram_rdata;
          best_idx_d = rd_idx_q;
        end
      end
    end

    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == ADDR_W'(TOTAL_WORDS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_fire) begin
          cmd_d      = req_i.cmd;
          wdata_d    = req_i.write_data;
          base_d     = ADDR_W'(page_sat) * ADDR_W'(SLOTS_PER_PAGE);
          cnt_d      = '0;
          best_idx_d = '0;
          best_val_d = (req_i.cmd == CMD_WRITE) ? ERASED_WORD : ZERO_WORD;
          found_d    = 1'b0;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_vld_d = 1'b1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == SLOT_W'(SLOTS_PER_PAGE - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_idx_d = best_idx_wide[IDX_W-1:0];
          if (cmd_q == CMD_WRITE) begin
            out_data_d = wdata_q;
          end else begin
            out_data_d = found_q ? best_val_q : word0_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    cmd_q      <= cmd_d;
    wdata_q    <= wdata_d;
    base_q     <= base_d;
    rd_idx_q   <= rd_idx_d;
    best_idx_q <= best_idx_d;
    best_val_q <= best_val_d;
    found_q    <= found_d;
    word0_q    <= word0_d;
    out_idx_q  <= out_idx_d;
    out_data_q <= out_data_d;
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.slot_index = out_idx_q;
  assign rsp_o.read_data  = out_data_q;

endmodule
